@@ hw/rtl/clal_pkg.sv @@
`default_nettype none

package clal_pkg;

  localparam int unsigned CODE_LEN = 4;

  // Lock mode, one-hot inside the block.
  typedef enum logic [2:0] {
    ST_ENTRY = 3'b001,
    ST_OPEN  = 3'b010,
    ST_ALARM = 3'b100
  } lock_state_t;

  // Mode code as seen on the result stream.
  localparam logic [1:0] MODE_ENTRY = 2'd0;
  localparam logic [1:0] MODE_OPEN  = 2'd1;
  localparam logic [1:0] MODE_ALARM = 2'd2;

  // Input kind carried in tuser.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  localparam logic [2:0] EXIT_BUTTON = 3'd7;
  localparam logic [3:0] COUNT_MAX   = 4'd15;
  localparam logic [3:0] LEDS_ALL    = 4'hf;

  // Configuration register indexes.
  localparam logic [2:0] REG_DIGIT_0  = 3'd0;
  localparam logic [2:0] REG_DIGIT_1  = 3'd1;
  localparam logic [2:0] REG_DIGIT_2  = 3'd2;
  localparam logic [2:0] REG_DIGIT_3  = 3'd3;
  localparam logic [2:0] REG_FLASH_ON = 3'd4;
  localparam logic [2:0] REG_PERIOD   = 3'd5;
  localparam logic [2:0] REG_REPEATS  = 3'd6;
  localparam logic [2:0] REG_PRESSES  = 3'd7;

  typedef struct packed {
    logic [3:0] code_leds;
    logic       door_led;
    logic       buzzer;
    logic [1:0] mode;
  } clal_result_t;

  function automatic logic [3:0] sat_inc(input logic [3:0] v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 4'd1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/clal_core.sv @@
`default_nettype none

module clal_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_addr,
  input  wire logic [3:0]            cfg_wdata,
  input  wire logic                  accept,
  input  wire logic                  press,
  input  wire logic [2:0]            button,
  output clal_pkg::clal_result_t     result
);
  import clal_pkg::*;

  logic [2:0] code_digit_r [CODE_LEN];
  logic [3:0] flash_on_r, flash_period_r, flash_repeats_r, reset_presses_r;

  lock_state_t state_r, state_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  digit_r [CODE_LEN-1];
  logic [3:0]  tick_r, tick_nxt;
  logic [3:0]  periods_r, periods_nxt;
  logic [3:0]  presses_r, presses_nxt;
  logic        code_match;
  logic [3:0]  tick_inc, press_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_digit_r[0] <= 3'd3;
      code_digit_r[1] <= 3'd5;
      code_digit_r[2] <= 3'd4;
      code_digit_r[3] <= 3'd5;
      flash_on_r      <= 4'd5;
      flash_period_r  <= 4'd7;
      flash_repeats_r <= 4'd3;
      reset_presses_r <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DIGIT_0:  code_digit_r[0] <= cfg_wdata[2:0];
        REG_DIGIT_1:  code_digit_r[1] <= cfg_wdata[2:0];
        REG_DIGIT_2:  code_digit_r[2] <= cfg_wdata[2:0];
        REG_DIGIT_3:  code_digit_r[3] <= cfg_wdata[2:0];
        REG_FLASH_ON: flash_on_r      <= cfg_wdata;
        REG_PERIOD:   flash_period_r  <= cfg_wdata;
        REG_REPEATS:  flash_repeats_r <= cfg_wdata;
        REG_PRESSES:  reset_presses_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The fourth digit is compared straight from the input, so only the first
  // three need storage.
  always_ff @(posedge clk) begin
    if (accept && press && state_r == ST_ENTRY && pos_r[2] == 1'b0 && pos_r[1:0] != 2'd3)
      digit_r[pos_r[1:0]] <= button;
  end

  assign code_match = (digit_r[0] == code_digit_r[0]) && (digit_r[1] == code_digit_r[1])
                   && (digit_r[2] == code_digit_r[2]) && (button == code_digit_r[3]);
  assign tick_inc   = sat_inc(tick_r);
  assign press_inc  = sat_inc(presses_r);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    tick_nxt    = tick_r;
    periods_nxt = periods_r;
    presses_nxt = presses_r;
    unique case (state_r)
      ST_ENTRY: begin
        if (press) begin
          pos_nxt = pos_r + 3'd1;
          if (pos_r == 3'd3) begin
            state_nxt = code_match ? ST_OPEN : ST_ALARM;
            tick_nxt  = 4'd0;
          end
        end
      end
      ST_OPEN, ST_ALARM: begin
        if (press) begin
          if (button == EXIT_BUTTON) begin
            presses_nxt = press_inc;
            if (press_inc >= reset_presses_r) begin
              state_nxt   = ST_ENTRY;
              pos_nxt     = 3'd0;
              tick_nxt    = 4'd0;
              periods_nxt = 4'd0;
              presses_nxt = 4'd0;
            end
          end
        end else if (state_r == ST_OPEN && tick_inc >= flash_period_r) begin
          tick_nxt    = 4'd0;
          periods_nxt = sat_inc(periods_r);
        end else begin
          tick_nxt = tick_inc;
        end
      end
      default: begin
        state_nxt   = ST_ENTRY;
        pos_nxt     = 3'd0;
        tick_nxt    = 4'd0;
        periods_nxt = 4'd0;
        presses_nxt = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_ENTRY;
      pos_r     <= 3'd0;
      tick_r    <= 4'd0;
      periods_r <= 4'd0;
      presses_r <= 4'd0;
    end else if (accept) begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      tick_r    <= tick_nxt;
      periods_r <= periods_nxt;
      presses_r <= presses_nxt;
    end
  end

  // Outputs show the state after the item.
  always_comb begin
    result = '0;
    unique case (state_nxt)
      ST_OPEN: begin
        result.mode     = MODE_OPEN;
        result.door_led = 1'b1;
        if (tick_nxt < flash_on_r && periods_nxt < flash_repeats_r)
          result.code_leds = LEDS_ALL;
      end
      ST_ALARM: begin
        result.mode      = MODE_ALARM;
        result.code_leds = LEDS_ALL;
        result.buzzer    = 1'b1;
        result.door_led  = ~tick_nxt[0];
      end
      default: begin
        result.mode = MODE_ENTRY;
        unique case (pos_nxt)
          3'd0:    result.code_leds = 4'b0000;
          3'd1:    result.code_leds = 4'b0001;
          3'd2:    result.code_leds = 4'b0011;
          3'd3:    result.code_leds = 4'b0111;
          default: result.code_leds = 4'b1111;
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/clal_out_reg.sv @@
`default_nettype none

module clal_out_reg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire clal_pkg::clal_result_t result,
  output logic                       can_load,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata
);
  import clal_pkg::*;

  logic         valid_r;
  clal_result_t data_r;

  // A new result may replace the held one in the cycle it is taken.
  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.mode, data_r.buzzer, data_r.door_led, data_r.code_leds};

endmodule

`default_nettype wire

@@ hw/rtl/combination_lock_alarm_unit.sv @@
// The result of an accepted input transaction is registered and appears on the output in the next cycle.
// Throughput: one transaction per cycle; the input is held off only while a result
// waits in the output register and the downstream side is not ready.
// Reset: synchronous, active low; the lock returns to entry mode and the code registers,
// flash settings and exit press count take their power-on values.
`default_nettype none

module combination_lock_alarm_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration write port; register index selects the setting.
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_addr,
  input  wire logic [3:0] cfg_wdata,
  // Input stream.
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,  // [2:0] button, [7:3] zero
  input  wire logic       in_tuser,  // [0] opcode (0 tick, 1 press)
  // Result stream.
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata  // [3:0] code_leds, [4] door_led, [5] buzzer, [7:6] mode
);
  import clal_pkg::*;

  logic         accept;
  clal_result_t result;

  // A transaction is taken whenever the output register is free or is being
  // emptied in the same cycle, so items can flow in every cycle.
  assign accept = in_tvalid && in_tready;

  // The core holds the lock state and settings and works out, in one pass of
  // logic, the next state and the LED, door and buzzer levels that follow it.
  clal_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .press     (in_tuser == OP_PRESS),
    .button    (in_tdata[2:0]),
    .result    (result)
  );

  // The output register holds each result until the downstream side takes it.
  clal_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .result     (result),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/clal_checker.sv @@
`default_nettype none

module clal_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);
  import clal_pkg::*;

  // A held result must not change until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted transaction shows its result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("result missing after accepted transaction");

  // In alarm mode the buzzer sounds and all code LEDs are lit.
  a_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] == MODE_ALARM |-> out_tdata[5] && out_tdata[3:0] == LEDS_ALL)
    else $error("alarm outputs wrong");

  // In entry mode the door LED and buzzer are dark.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7:6] == MODE_ENTRY |-> !out_tdata[4] && !out_tdata[5])
    else $error("entry outputs wrong");

endmodule

bind combination_lock_alarm_unit clal_checker u_clal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
